// ===== hw/rtl/lozb_pkg.sv =====
// ----------------------------------------------------------------------------
// lozb_pkg: shared types and constants for the longest-ones window block
// Field widths, default sizing and the FIFO cell control bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package lozb_pkg;

	localparam int BUDGET_W = 7;
	localparam int LEN_W = 16;
	localparam int MAX_ZEROS_DEF = 64;
	localparam int MAX_LEN_DEF = 65535;

	// broadcast to every cell of the zero-position queue
	typedef struct packed {
		logic pop;   // queue shifts one place toward cell 0
		logic push;  // cell at the write index loads the new position
	} cell_ctrl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/lozb_in_if.sv =====
// ----------------------------------------------------------------------------
// lozb_in_if: input bit stream channel
// One sequence element per transaction, with an end-of-sequence marker.
// ----------------------------------------------------------------------------
`default_nettype none

interface lozb_in_if;
	logic valid;
	logic ready;
	logic bit_value;
	logic seq_last;

	modport source (output valid, output bit_value, output seq_last, input ready);
	modport sink (input valid, input bit_value, input seq_last, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/lozb_out_if.sv =====
// ----------------------------------------------------------------------------
// lozb_out_if: result channel
// Running best length and current window length for each element.
// ----------------------------------------------------------------------------
`default_nettype none

interface lozb_out_if;
	logic                        valid;
	logic                        ready;
	logic [lozb_pkg::LEN_W-1:0] best_length;
	logic [lozb_pkg::LEN_W-1:0] window_length;
	logic                        is_final;
	logic                        overflow;

	modport source (output valid, output best_length, output window_length,
		output is_final, output overflow, input ready);
	modport sink (input valid, input best_length, input window_length,
		input is_final, input overflow, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/lozb_cell.sv =====
// ----------------------------------------------------------------------------
// lozb_cell: one slot of the compacting zero-position queue
// Holds one position; shifts in its upper neighbor on pop, loads on push.
// ----------------------------------------------------------------------------
`default_nettype none

module lozb_cell #(
	parameter int POS_W = 16,
	parameter int CNT_W = 7,
	parameter int IDX = 0
) (
	input  wire                      clk,
	input  wire lozb_pkg::cell_ctrl_t ctrl,
	input  wire  [CNT_W-1:0]         wr_idx,
	input  wire  [POS_W-1:0]         wr_pos,
	input  wire  [POS_W-1:0]         nbr_pos,
	output logic [POS_W-1:0]         pos_q
);

	logic hit;

	assign hit = ctrl.push && (wr_idx == CNT_W'(IDX));

	always_ff @(posedge clk) begin
		if (hit) begin
			pos_q <= wr_pos;
		end else if (ctrl.pop) begin
			pos_q <= nbr_pos;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/longest_ones_with_zero_budget_top.sv =====
// Each result is registered in the output buffer when its input is accepted.
// Throughput: one element per cycle while the skid entry is free; the window
// update is a combinational subtract and compare, oldest zero always at cell 0.
// A two-entry output buffer keeps input flowing while one result waits.
// Reset (arst_n low, asynchronous) clears the sequence state and budget;
// sequence state also clears after each element marked seq_last.
// ----------------------------------------------------------------------------
// longest_ones_with_zero_budget_top: longest window with limited zeros
// Sliding window over a bit stream, zero positions held in a chain of cells.
// ----------------------------------------------------------------------------
`default_nettype none

module longest_ones_with_zero_budget_top #(
	parameter int MAX_ZEROS = lozb_pkg::MAX_ZEROS_DEF,
	parameter int MAX_LEN = lozb_pkg::MAX_LEN_DEF
) (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           cfg_we,
	input  wire  [lozb_pkg::BUDGET_W-1:0] cfg_wdata,
	lozb_in_if.sink                       item_in,
	lozb_out_if.source                    result_out
);

	localparam int POS_W = $clog2(MAX_LEN + 1);
	localparam int CNT_W = $clog2(MAX_ZEROS + 1);
	localparam int BW = (CNT_W > lozb_pkg::BUDGET_W) ? CNT_W : lozb_pkg::BUDGET_W;
	localparam int EXT_W = (POS_W > lozb_pkg::LEN_W) ? POS_W : lozb_pkg::LEN_W;
	localparam int RES_W = 2 * lozb_pkg::LEN_W + 2;

	logic [lozb_pkg::BUDGET_W-1:0] budget_q;
	logic [POS_W-1:0]              pos_q, start_q, best_q;
	logic [CNT_W-1:0]              count_q;
	logic                          ovf_q;

	logic [POS_W-1:0]              pos_n, start_n, best_n, wlen_n;
	logic [CNT_W-1:0]              count_n, budget_eff, wr_idx;
	logic                          ovf_n;
	logic [BW-1:0]                 budget_ext;
	logic                          accept, proceed, zero_in;
	lozb_pkg::cell_ctrl_t          ctrl;
	logic [POS_W-1:0]              cell_pos [MAX_ZEROS];

	logic [RES_W-1:0]              res, o_q, s_q;
	logic                          o_v_q, s_v_q, out_fire;

	// ---------------- configuration ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			budget_q <= '0;
		end else if (cfg_we) begin
			budget_q <= cfg_wdata;
		end
	end

	assign budget_ext = BW'(budget_q);
	assign budget_eff = (budget_ext > BW'(MAX_ZEROS)) ? CNT_W'(MAX_ZEROS)
		: CNT_W'(budget_ext);

	// ---------------- window update ----------------
	assign item_in.ready = !s_v_q;
	assign accept = item_in.valid && !s_v_q;
	assign proceed = accept && (pos_q < POS_W'(MAX_LEN));
	assign zero_in = proceed && !item_in.bit_value;

	assign ctrl.push = zero_in && (budget_eff != '0);
	assign ctrl.pop = ctrl.push && (count_q >= budget_eff);
	assign wr_idx = count_q - CNT_W'(ctrl.pop);

	always_comb begin
		pos_n = pos_q;
		start_n = start_q;
		count_n = count_q;
		ovf_n = ovf_q;
		if (accept && !proceed) begin
			ovf_n = 1'b1;
		end
		if (proceed) begin
			pos_n = pos_q + POS_W'(1);
		end
		if (zero_in && budget_eff == '0) begin
			count_n = '0;
			start_n = pos_q + POS_W'(1);
		end else if (ctrl.push) begin
			count_n = wr_idx + CNT_W'(1);
			if (ctrl.pop) begin
				start_n = cell_pos[0] + POS_W'(1);
			end
		end
		wlen_n = pos_n - start_n;
		best_n = (proceed && wlen_n > best_q) ? wlen_n : best_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			start_q <= '0;
			count_q <= '0;
			best_q <= '0;
			ovf_q <= 1'b0;
		end else if (accept) begin
			if (item_in.seq_last) begin
				pos_q <= '0;
				start_q <= '0;
				count_q <= '0;
				best_q <= '0;
				ovf_q <= 1'b0;
			end else begin
				pos_q <= pos_n;
				start_q <= start_n;
				count_q <= count_n;
				best_q <= best_n;
				ovf_q <= ovf_n;
			end
		end
	end

	// ---------------- zero-position queue, oldest at cell 0 ----------------
	for (genvar i = 0; i < MAX_ZEROS; i++) begin : g_cell
		logic [POS_W-1:0] nbr;
		if (i == MAX_ZEROS - 1) begin : g_end
			assign nbr = '0;
		end else begin : g_mid
			assign nbr = cell_pos[i+1];
		end
		lozb_cell #(
			.POS_W(POS_W),
			.CNT_W(CNT_W),
			.IDX(i)
		) u_cell (
			.clk(clk),
			.ctrl(ctrl),
			.wr_idx(wr_idx),
			.wr_pos(pos_q),
			.nbr_pos(nbr),
			.pos_q(cell_pos[i])
		);
	end

	// ---------------- result formatting ----------------
	function automatic logic [lozb_pkg::LEN_W-1:0] sat_len(input logic [POS_W-1:0] v);
		logic [EXT_W-1:0] e;
		e = EXT_W'(v);
		sat_len = (e > EXT_W'({lozb_pkg::LEN_W{1'b1}})) ? {lozb_pkg::LEN_W{1'b1}}
			: e[lozb_pkg::LEN_W-1:0];
	endfunction

	assign res = {sat_len(best_n), sat_len(wlen_n), item_in.seq_last, ovf_n};

	// ---------------- two-entry output buffer ----------------
	assign out_fire = o_v_q && result_out.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			o_v_q <= 1'b0;
			s_v_q <= 1'b0;
		end else if (!o_v_q || out_fire) begin
			o_v_q <= s_v_q || accept;
			s_v_q <= s_v_q && accept;
		end else if (accept) begin
			s_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!o_v_q || out_fire) begin
			if (s_v_q) begin
				o_q <= s_q;
				if (accept) begin
					s_q <= res;
				end
			end else if (accept) begin
				o_q <= res;
			end
		end else if (accept) begin
			s_q <= res;
		end
	end

	assign result_out.valid = o_v_q;
	assign result_out.best_length = o_q[RES_W-1 -: lozb_pkg::LEN_W];
	assign result_out.window_length = o_q[2 +: lozb_pkg::LEN_W];
	assign result_out.is_final = o_q[1];
	assign result_out.overflow = o_q[0];

`ifndef NO_ASSERTIONS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_ZEROS))
		else $error("zero queue count above capacity");

	a_start_le_pos: assert property (@(posedge clk) disable iff (!arst_n)
		start_q <= pos_q)
		else $error("window start past current position");

	a_skid_order: assert property (@(posedge clk) disable iff (!arst_n)
		s_v_q |-> o_v_q)
		else $error("skid entry held with empty output register");

	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && item_in.seq_last) |=> (pos_q == '0 && count_q == '0 && !ovf_q))
		else $error("sequence state not cleared after last element");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.pop |-> (count_q != '0))
		else $error("pop from empty zero queue");
`endif

endmodule

`default_nettype wire

// ===== tb/lozb_window_checker.sv =====
// ----------------------------------------------------------------------------
// lozb_window_checker: result predictor and comparator for the window block
// Follows every input transaction and budget write, predicts the best and
// current window lengths, and compares each result in arrival order.
// ----------------------------------------------------------------------------
module lozb_window_checker #(
	parameter int MAX_ZEROS = lozb_pkg::MAX_ZEROS_DEF,
	parameter int MAX_LEN = lozb_pkg::MAX_LEN_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [lozb_pkg::BUDGET_W-1:0] cfg_wdata,
	lozb_in_if                            item_in,
	lozb_out_if                           result_out,
	output int                            mismatches,
	output int                            pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef logic [31:0] pos_t;

	typedef struct packed {
		logic [lozb_pkg::LEN_W-1:0] best_length;
		logic [lozb_pkg::LEN_W-1:0] window_length;
		logic                       is_final;
		logic                       overflow;
	} window_result_t;

	// predictor state
	logic [lozb_pkg::BUDGET_W-1:0] budget_reg;
	pos_t                seq_pos;
	pos_t                win_start;
	pos_t                best_run;
	pos_t                zero_q[$];
	logic                seq_ovf;

	window_result_t      window_results_q[$];

	function automatic void clear_sequence();
		seq_pos = '0;
		win_start = '0;
		best_run = '0;
		seq_ovf = 1'b0;
		zero_q.delete();
	endfunction

	function automatic logic [lozb_pkg::LEN_W-1:0] clamp16(input pos_t v);
		return (v > pos_t'(16'hFFFF)) ? 16'hFFFF : v[lozb_pkg::LEN_W-1:0];
	endfunction

	function automatic window_result_t advance_window(input logic b, input logic closes);
		window_result_t r;
		int unsigned    allowed;
		pos_t           run_len;
		allowed = (budget_reg > MAX_ZEROS) ? MAX_ZEROS : budget_reg;
		if (seq_pos >= MAX_LEN) begin
			// past the length limit the window freezes
			seq_ovf = 1'b1;
		end else begin
			if (!b) begin
				if (allowed == 0) begin
					zero_q.delete();
					win_start = seq_pos + 1;
				end else begin
					// only the oldest zero leaves, even if the budget dropped
					if (zero_q.size() >= allowed)
						win_start = zero_q.pop_front() + 1;
					zero_q.push_back(seq_pos);
				end
			end
			seq_pos = seq_pos + 1;
			if (seq_pos - win_start > best_run)
				best_run = seq_pos - win_start;
		end
		run_len = seq_pos - win_start;
		r.best_length = clamp16(best_run);
		r.window_length = clamp16(run_len);
		r.is_final = closes;
		r.overflow = seq_ovf;
		if (closes)
			clear_sequence();
		return r;
	endfunction

	task automatic flag(input string field, input int unsigned want, input int unsigned got);
		$display("%0t ns: %s expected %0d actual %0d", $time, field, want, got);
		mismatches++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		window_result_t want;
		window_result_t got;
		if (!arst_n) begin
			budget_reg = '0;
			clear_sequence();
			window_results_q.delete();
			mismatches = 0;
			pending = 0;
		end else begin
			if (cfg_we)
				budget_reg = cfg_wdata;
			// check the older result before queueing this edge's transaction
			if (result_out.valid && result_out.ready) begin
				got.best_length = result_out.best_length;
				got.window_length = result_out.window_length;
				got.is_final = result_out.is_final;
				got.overflow = result_out.overflow;
				if (window_results_q.size() == 0) begin
					$display("%0t ns: result with nothing expected, best %0d window %0d",
						$time, got.best_length, got.window_length);
					mismatches++;
				end else begin
					want = window_results_q.pop_front();
					if (got.best_length !== want.best_length)
						flag("best_length", want.best_length, got.best_length);
					if (got.window_length !== want.window_length)
						flag("window_length", want.window_length, got.window_length);
					if (got.is_final !== want.is_final)
						flag("is_final", want.is_final, got.is_final);
					if (got.overflow !== want.overflow)
						flag("overflow", want.overflow, got.overflow);
				end
			end
			if (item_in.valid && item_in.ready)
				window_results_q.push_back(advance_window(item_in.bit_value, item_in.seq_last));
			pending = window_results_q.size();
		end
	end

endmodule

// ===== tb/longest_ones_with_zero_budget_top_tb.sv =====
// ----------------------------------------------------------------------------
// longest_ones_with_zero_budget_top_tb: stimulus and verdict for the block
// Directed bit patterns, then random sequences under three idle profiles,
// budget changes between and inside sequences and a long receiver hold-off.
// ----------------------------------------------------------------------------
module longest_ones_with_zero_budget_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STALL_LIMIT = 3000;
	localparam int RX_HOLD = 400;

	logic                          clk;
	logic                          arst_n;
	logic                          cfg_we;
	logic [lozb_pkg::BUDGET_W-1:0] cfg_wdata;

	int   send_idle_pct;
	int   recv_idle_pct;
	logic hold_recv;
	int   mismatches;
	int   pending;
	int   quiet_cycles;

	lozb_in_if  bits_ch();
	lozb_out_if runs_ch();

	longest_ones_with_zero_budget_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.item_in   (bits_ch),
		.result_out(runs_ch)
	);

	lozb_window_checker u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.item_in   (bits_ch),
		.result_out(runs_ch),
		.mismatches(mismatches),
		.pending   (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// watchdog: too long without any transaction on either channel
	always @(posedge clk) begin
		if (!arst_n || (bits_ch.valid && bits_ch.ready) || (runs_ch.valid && runs_ch.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// result side: random back-pressure, or a long hold when asked
	initial begin
		runs_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_recv) begin
				runs_ch.ready <= 1'b0;
				repeat (RX_HOLD) @(posedge clk);
				hold_recv = 1'b0;
			end else begin
				runs_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	task automatic offer_bit(input logic b, input logic closes);
		while ($urandom_range(99) < send_idle_pct) begin
			bits_ch.valid <= 1'b0;
			@(posedge clk);
		end
		bits_ch.valid <= 1'b1;
		bits_ch.bit_value <= b;
		bits_ch.seq_last <= closes;
		@(posedge clk);
		while (!bits_ch.ready) @(posedge clk);
	endtask

	// bits go out MSB first
	task automatic offer_pattern(input logic [31:0] bits, input int n, input logic closes);
		for (int i = n - 1; i >= 0; i--)
			offer_bit(bits[i], closes && (i == 0));
	endtask

	// budget writes only once every result is back
	task automatic write_budget(input logic [lozb_pkg::BUDGET_W-1:0] v);
		bits_ch.valid <= 1'b0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
		repeat (2) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [lozb_pkg::BUDGET_W-1:0] pick_budget();
		case ($urandom_range(5))
			0: return '0;
			1: return lozb_pkg::BUDGET_W'($urandom_range(1, 3));
			2: return lozb_pkg::BUDGET_W'(lozb_pkg::MAX_ZEROS_DEF);
			3: return '1;
			default: return lozb_pkg::BUDGET_W'($urandom_range(0, 127));
		endcase
	endfunction

	task automatic run_random(input int n);
		int count;
		int len;
		int zero_pct;
		count = 0;
		while (count < n) begin
			if ($urandom_range(3) == 0)
				write_budget(pick_budget());
			// a few long runs so a budget of 64 wraps the zero queue
			len = ($urandom_range(7) == 0) ? $urandom_range(80, 160) : $urandom_range(1, 40);
			zero_pct = $urandom_range(5, 70);
			for (int i = 0; i < len; i++) begin
				if (i > 0 && $urandom_range(39) == 0)
					write_budget(pick_budget());
				offer_bit($urandom_range(99) >= zero_pct, i == len - 1);
			end
			count += len;
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= '0;
		bits_ch.valid <= 1'b0;
		bits_ch.bit_value <= 1'b0;
		bits_ch.seq_last <= 1'b0;
		hold_recv = 1'b0;
		send_idle_pct = 30;
		recv_idle_pct = 66;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// budget zero after reset: a zero empties the window
		offer_pattern(32'b11011, 5, 1'b1);
		write_budget(2);
		offer_pattern(32'b00010, 5, 1'b1);
		// above the queue depth, clamps
		write_budget('1);
		offer_pattern(32'b010, 3, 1'b1);
		// lowered mid-sequence, window keeps extra zeros
		write_budget(3);
		offer_pattern(32'b0001, 4, 1'b0);
		write_budget(1);
		offer_pattern(32'b101, 3, 1'b1);
		// dropped to zero mid-sequence
		write_budget(3);
		offer_pattern(32'b001, 3, 1'b0);
		write_budget(0);
		offer_pattern(32'b01, 2, 1'b1);

		run_random(230);
		send_idle_pct = 66;
		recv_idle_pct = 30;
		run_random(230);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_recv = 1'b1;
		// sender keeps offering with no budget write so the block fills
		offer_pattern(32'b11010111, 8, 1'b1);
		run_random(230);

		run_random(20);

		bits_ch.valid <= 1'b0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
		repeat (4) @(posedge clk);
		@(negedge clk);
		if (mismatches == 0 && pending == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
